// ===== rtl/encoder_count_to_electrical_angle_core_macros.svh =====
// Assertion macros shared by the checker of the encoder angle core.
`ifndef ENCODER_COUNT_TO_ELECTRICAL_ANGLE_CORE_MACROS_SVH
`define ENCODER_COUNT_TO_ELECTRICAL_ANGLE_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ECEA_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ECEA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ecea_pkg.sv =====
// Types and constants of the encoder count to electrical angle core.
package ecea_pkg;

  localparam int unsigned LINES_W   = 15;
  localparam int unsigned POLES_W   = 7;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned DVD_W     = 32;
  localparam int unsigned DVS_W     = LINES_W + 2;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = 5;
  localparam int unsigned ANGLE_SHIFT = 14;
  localparam int unsigned LIM_W     = LINES_W + 8;
  localparam int unsigned DROP_W    = LINES_W + 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LINES_W-1:0] LINES_RST  = 15'd1024;
  localparam logic [POLES_W-1:0] POLES_RST  = 7'd4;
  localparam logic [LIM_W-1:0]   TURN_LIMIT = 23'd200;
  localparam logic [DROP_W-1:0]  TURN_DROP  = 22'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_LINES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLES = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_REZERO = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV1,
    ST_DIV2,
    ST_FIN
  } ecea_state_t;

endpackage

// ===== rtl/ecea_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ecea_sdiv import ecea_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quo,
  output logic [DVS_W-1:0] rem
);

  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/encoder_count_to_electrical_angle_core.sv =====
// Quadrature counter samples to electrical rotor angle and running position.
// A sample item passes the states PREP, DIV1, DIV2 and FIN before its result is
// loaded; a re-zero item goes straight to FIN. One bit-serial divider is run twice.
// Items are taken one at a time, only in IDLE; the next item is taken while a
// result waits. Synchronous active-low reset clears the position state and
// loads 1024 lines and 4 pole pairs.
module encoder_count_to_electrical_angle_core import ecea_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // counter_value[31:0]
  input  logic [0:0]           in_tuser,   // op[0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // elec_angle[15:0], position_total[47:16]
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [LINES_W-1:0]   cfg_wdata
);

  ecea_state_t state_r, state_nxt;

  logic [LINES_W-1:0] lines_r;
  logic [POLES_W-1:0] poles_r;
  logic [LINES_W-1:0] leff_r;
  logic [LINES_W-1:0] leff;
  logic [LIM_W-1:0]   lim_r;
  logic [DROP_W-1:0]  drop_r;
  logic [CNT_W-1:0]   last_r;
  logic [CNT_W-1:0]   total_r;
  logic [CNT_W-1:0]   tot_r;
  logic [CNT_W-1:0]   mag;
  logic               neg_r;
  logic               over_r;
  logic [ANGLE_W-1:0] qs_r;
  logic [ANGLE_W-1:0] prod;
  logic               out_valid_r;
  logic [ANGLE_W-1:0] out_angle_r;
  logic [CNT_W-1:0]   out_pos_r;

  logic               in_acc;
  logic               div_start;
  logic               fin_load;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_quo;
  logic [DVS_W-1:0]   div_rem;

  ecea_sdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign in_acc = in_tvalid && in_tready;
  assign leff   = (lines_r == '0) ? LINES_W'(1) : lines_r;
  assign mag    = tot_r[CNT_W-1] ? (~tot_r + 1'b1) : tot_r;
  assign prod   = qs_r * {{(ANGLE_W-POLES_W){1'b0}}, poles_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_tuser[0] == OP_REZERO) ? ST_FIN : ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_DIV1;
      ST_DIV1: begin
        if (div_done) begin
          state_nxt = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    fin_load  = 1'b0;
    div_dvd   = mag;
    div_dvs   = {leff_r, 2'b00};
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_PREP: div_start = 1'b1;
      ST_DIV1: begin
        div_start = div_done;
        div_dvd   = {1'b0, div_rem, {ANGLE_SHIFT{1'b0}}};
        div_dvs   = {2'b00, leff_r};
      end
      ST_FIN:  fin_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lines_r     <= LINES_RST;
      poles_r     <= POLES_RST;
      last_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LINES: lines_r <= cfg_wdata;
          CFG_POLES: poles_r <= cfg_wdata[POLES_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        last_r <= in_tdata;
        if (in_tuser[0] == OP_REZERO) begin
          total_r <= '0;
        end
      end
      if (state_r == ST_DIV1 && div_done && over_r) begin
        total_r <= neg_r ? (tot_r + {{(CNT_W-DROP_W){1'b0}}, drop_r})
                         : (tot_r - {{(CNT_W-DROP_W){1'b0}}, drop_r});
      end else if (state_r == ST_DIV1 && div_done) begin
        total_r <= tot_r;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tot_r  <= total_r + (in_tdata - last_r);
      leff_r <= leff;
      lim_r  <= {8'b0, leff} * TURN_LIMIT;
      drop_r <= {7'b0, leff} * TURN_DROP;
      qs_r   <= '0;
    end
    if (state_r == ST_PREP) begin
      neg_r  <= tot_r[CNT_W-1];
      over_r <= mag > {{(CNT_W-LIM_W){1'b0}}, lim_r};
    end
    if (state_r == ST_DIV2 && div_done) begin
      qs_r <= neg_r ? (~div_quo[ANGLE_W-1:0] + 1'b1) : div_quo[ANGLE_W-1:0];
    end
    if (fin_load) begin
      out_angle_r <= prod;
      out_pos_r   <= total_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, out_angle_r};

endmodule

// ===== rtl/ecea_checker.sv =====
// Port-level checker of the encoder angle core, bound to the top level.
`include "encoder_count_to_electrical_angle_core_macros.svh"

module ecea_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic        stall;
  logic [15:0] angle;
  logic [31:0] pos;

  assign stall = out_tvalid && !out_tready;
  assign angle = out_tdata[15:0];
  assign pos   = out_tdata[47:16];

  // A stalled result keeps its value.
  `ECEA_ASSERT_RUN(a_out_hold, stall |=> out_tvalid && $stable(out_tdata), "result not held")
  // Reset leaves no result pending.
  `ECEA_ASSERT_ALL(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  // The block works on one item at a time.
  `ECEA_ASSERT_RUN(a_one_item, in_tvalid && in_tready |=> !in_tready, "item taken while busy")
  // A zero position always comes with a zero angle.
  `ECEA_ASSERT_RUN(a_zero_angle, out_tvalid && pos == '0 |-> angle == '0, "angle at zero position")

endmodule

bind encoder_count_to_electrical_angle_core ecea_checker u_ecea_checker (.*);
